@@ rtl/core/txc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Shared geometry, field widths, action codes and controller/datapath types.
// ----------------------------------------------------------------------------
package txc_pkg;

	// Screen geometry.
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int ADDR_W  = $clog2(CELLS);

	// Field widths.
	localparam int ACT_W    = 2;
	localparam int CHAR_W   = 8;
	localparam int COLOR_W  = 8;
	localparam int COL_W    = 7;
	localparam int ROW_W    = 5;
	localparam int OFFSET_W = 11;
	localparam int CELL_W   = CHAR_W + COLOR_W;

	// Actions.
	localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_PUT_CHAR = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PUT_CELL = 2'd2;
	localparam logic [ACT_W-1:0] ACT_READ     = 2'd3;

	// Special characters.
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

	// Attribute after reset and the cell value of a freshly reset store.
	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
	localparam logic [CELL_W-1:0]  RESET_CELL  = {RESET_COLOR, CH_BLANK};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // latch the accepted word
		logic exec;        // apply the latched action
		logic fill;        // write the fill value at the sweep counter
		logic fill_init;   // fill with the reset cell rather than the current blank
		logic copy;        // read one cell a row below for the scroll copy
		logic result_load; // load the result word
	} txc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             need_scroll;
		logic             cnt_last;
		logic             copy_last;
		logic             out_free;
	} txc_sts_t;

endpackage

@@ rtl/core/txc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console controller
// Sequences reset clearing, actions, clear sweeps, scrolls and the result.
// ----------------------------------------------------------------------------
module txc_ctrl
	import txc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  txc_sts_t sts,
	output txc_cmd_t cmd
);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_FILL  = 3'd3;
	localparam logic [2:0] ST_COPY  = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;
	localparam logic [2:0] ST_BLANK = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and command decode.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd_ready = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.fill      = 1'b1;
				cmd.fill_init = 1'b1;
				if (sts.cnt_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.action == ACT_CLEAR) begin
					state_d = ST_FILL;
				end else if (sts.action == ACT_PUT_CHAR && sts.need_scroll) begin
					state_d = ST_COPY;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (sts.cnt_last) begin
					state_d = ST_DONE;
				end
			end
			ST_COPY: begin
				cmd.copy = 1'b1;
				if (sts.copy_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// The last copied cell is written back in this cycle.
				state_d = ST_BLANK;
			end
			ST_BLANK: begin
				cmd.fill = 1'b1;
				if (sts.cnt_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.result_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/txc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console datapath
// Cell store, cursor, attribute register, sweep counter and result register.
// ----------------------------------------------------------------------------
module txc_datapath
	import txc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  txc_cmd_t            cmd,
	output txc_sts_t            sts,
	input  logic                cfg_write_en,
	input  logic [COLOR_W-1:0]  cfg_write_data,
	input  logic [ACT_W-1:0]    action,
	input  logic [CHAR_W-1:0]   character,
	input  logic [COLOR_W-1:0]  entry_color,
	input  logic [COL_W-1:0]    column,
	input  logic [ROW_W-1:0]    line,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [OFFSET_W-1:0] cursor_offset,
	output logic [CELL_W-1:0]   cell_data
);

	localparam logic [COL_W:0]   COL_LIMIT  = (COL_W + 1)'(COLUMNS);
	localparam logic [ROW_W:0]   ROW_LIMIT  = (ROW_W + 1)'(ROWS);
	localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] CNT_LAST  = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - COLUMNS - 1);

	// Linear cell address of a row and column.
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		cell_addr = ADDR_W'(32'(r) * COLUMNS + 32'(c));
	endfunction

	// Latched input word.
	logic [ACT_W-1:0]   act_q;
	logic [CHAR_W-1:0]  char_q;
	logic [COLOR_W-1:0] ecolor_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;

	// Architectural state.
	logic [COLOR_W-1:0] text_color_q;
	logic [COL_W-1:0]   cur_col_q;
	logic [ROW_W-1:0]   cur_row_q;

	// Sweep counter and the scroll copy stage.
	logic [ADDR_W-1:0] cnt_q;
	logic              copy_pend_q;
	logic [ADDR_W-1:0] copy_addr_q;

	// Store and its read port.
	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rdata_q;
	logic              rd_ok_q;
	logic              rsp_valid_q;

	logic              in_range;
	logic [CELL_W-1:0] blank;
	logic [COL_W-1:0]  pc_col;
	logic [ROW_W:0]    pc_row;
	logic              pc_wr;
	logic [COL_W-1:0]  pc_wcol;
	logic [ROW_W-1:0]  pc_wrow;
	logic [CHAR_W-1:0] pc_wchar;
	logic [ROW_W:0]    row_inc;
	logic [COL_W:0]    col_inc;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CELL_W-1:0] wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;

	assign in_range = ({1'b0, col_q} < COL_LIMIT) && ({1'b0, row_q} < ROW_LIMIT);
	assign blank    = {text_color_q, CH_BLANK};
	assign row_inc  = {1'b0, cur_row_q} + 1'b1;
	assign col_inc  = {1'b0, cur_col_q} + 1'b1;

	// Put-character cursor movement and cell write.
	always_comb begin
		pc_col   = cur_col_q;
		pc_row   = {1'b0, cur_row_q};
		pc_wr    = 1'b0;
		pc_wcol  = cur_col_q;
		pc_wrow  = cur_row_q;
		pc_wchar = char_q;
		if (char_q == CH_NEWLINE) begin
			pc_col = '0;
			pc_row = row_inc;
		end else if (char_q == CH_BACKSPACE) begin
			if (cur_col_q == '0) begin
				pc_col = COL_LAST;
				if (cur_row_q != '0) begin
					pc_row = {1'b0, cur_row_q - 1'b1};
				end
			end else begin
				pc_col = cur_col_q - 1'b1;
			end
			pc_wr    = 1'b1;
			pc_wcol  = pc_col;
			pc_wrow  = pc_row[ROW_W-1:0];
			pc_wchar = CH_BLANK;
		end else begin
			pc_wr = 1'b1;
			if (col_inc >= COL_LIMIT) begin
				pc_col = '0;
				pc_row = row_inc;
			end else begin
				pc_col = col_inc[COL_W-1:0];
			end
		end
	end

	// Write port select: a pending scroll copy, a sweep fill or the action's write.
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = cmd.fill_init ? RESET_CELL : blank;
		if (copy_pend_q) begin
			we    = 1'b1;
			waddr = copy_addr_q;
			wdata = rdata_q;
		end else if (cmd.fill) begin
			we = 1'b1;
		end else if (cmd.exec && act_q == ACT_PUT_CHAR) begin
			we    = pc_wr;
			waddr = cell_addr(pc_wrow, pc_wcol);
			wdata = {text_color_q, pc_wchar};
		end else if (cmd.exec && act_q == ACT_PUT_CELL) begin
			we    = in_range;
			waddr = cell_addr(row_q, col_q);
			wdata = {ecolor_q, char_q};
		end
	end

	// Read port select: a cell read or the scroll copy source.
	always_comb begin
		re    = 1'b0;
		raddr = cnt_q + ROW_STEP;
		if (cmd.copy) begin
			re = 1'b1;
		end else if (cmd.exec && act_q == ACT_READ) begin
			re    = in_range;
			raddr = cell_addr(row_q, col_q);
		end
	end

	// Cell store.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Latch the accepted word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q    <= action;
			char_q   <= character;
			ecolor_q <= entry_color;
			col_q    <= column;
			row_q    <= line;
		end
	end

	// Attribute register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
		end else if (cfg_write_en) begin
			text_color_q <= cfg_write_data;
		end
	end

	// Cursor and read status update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			rd_ok_q   <= 1'b0;
		end else if (cmd.exec) begin
			rd_ok_q <= (act_q == ACT_READ) && in_range;
			if (act_q == ACT_CLEAR) begin
				cur_col_q <= '0;
				cur_row_q <= '0;
			end else if (act_q == ACT_PUT_CHAR) begin
				cur_col_q <= pc_col;
				cur_row_q <= (pc_row >= ROW_LIMIT) ? ROW_LAST : pc_row[ROW_W-1:0];
			end
		end
	end

	// Sweep counter and the copy stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			copy_pend_q <= 1'b0;
		end else begin
			copy_pend_q <= cmd.copy;
			if (cmd.exec) begin
				cnt_q <= '0;
			end else if (cmd.fill || cmd.copy) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.copy) begin
			copy_addr_q <= cnt_q;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			cursor_offset <= OFFSET_W'(32'(cur_row_q) * COLUMNS + 32'(cur_col_q));
			cell_data     <= rd_ok_q ? rdata_q : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;

	// Status to the controller.
	assign sts.action      = act_q;
	assign sts.need_scroll = (pc_row >= ROW_LIMIT);
	assign sts.cnt_last    = (cnt_q == CNT_LAST);
	assign sts.copy_last   = (cnt_q == COPY_LAST);
	assign sts.out_free    = !rsp_valid_q || rsp_ready;

endmodule

@@ rtl/core/text_console_writer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// 80x25 text cell store with cursor, clear, scroll, cell writes and reads.
// ----------------------------------------------------------------------------
// After reset the block fills every cell of the store with blanks in
// color 7 and holds cmd_ready low meanwhile; attribute writes are taken at any
// time. Each word is then latched on acceptance, acted on in the store, and
// loaded into the result register once the output is free. A clear adds one
// store write per cell, and a put character that runs off the bottom adds a
// scroll: 1920 cells read and copied through the store's one read and one
// write port, a drain state to write back the last copied cell and a sweep
// that blanks the 80 cells of the bottom row. A new word is accepted while
// the previous result still waits on rsp_ready.
// ----------------------------------------------------------------------------
module text_console_writer_top
	import txc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic [COLOR_W-1:0]  cfg_write_data,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  logic [ACT_W-1:0]    action,
	input  logic [CHAR_W-1:0]   character,
	input  logic [COLOR_W-1:0]  entry_color,
	input  logic [COL_W-1:0]    column,
	input  logic [ROW_W-1:0]    line,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [OFFSET_W-1:0] cursor_offset,
	output logic [CELL_W-1:0]   cell_data
);

	txc_cmd_t cmd;
	txc_sts_t sts;

	// Controller.
	txc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath.
	txc_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.action         (action),
		.character      (character),
		.entry_color    (entry_color),
		.column         (column),
		.line           (line),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.cursor_offset  (cursor_offset),
		.cell_data      (cell_data)
	);

endmodule

@@ bench/text_console_writer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives words into the console and checks each cursor offset and cell read
// against a shadow copy of the screen, cursor and attribute kept in the bench.
// Directed tests cover the store corners, out-of-range positions, backspace
// and wrap at the screen edges, and clear. Random traffic then runs text,
// newline bursts that scroll the screen, cell writes with read-back, clears
// and noise, under several attribute settings, with random idling on both
// sides of the handshake.
// ----------------------------------------------------------------------------
module text_console_writer_top_tb;
	import txc_pkg::*;

	localparam int TIMEOUT_NS   = 70_000_000;
	localparam int IDLE_SETTLE  = 8;
	localparam int DRAIN_CYCLES = 2100;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [CELL_W-1:0]   cell_word;
	} console_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_write_en = 1'b0;
	logic [COLOR_W-1:0]  cfg_write_data = '0;
	logic                cmd_valid = 1'b0;
	logic                cmd_ready;
	logic [ACT_W-1:0]    action = '0;
	logic [CHAR_W-1:0]   character = '0;
	logic [COLOR_W-1:0]  entry_color = '0;
	logic [COL_W-1:0]    column = '0;
	logic [ROW_W-1:0]    line = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	logic [OFFSET_W-1:0] cursor_offset;
	logic [CELL_W-1:0]   cell_data;

	// Shadow state of the console.
	logic [CELL_W-1:0]  screen_cells [CELLS];
	int unsigned        cur_col;
	int unsigned        cur_row;
	logic [COLOR_W-1:0] screen_attr;

	console_result_t pending_results [$];
	int              error_count = 0;
	bit              quiet = 1'b0;
	int              hold_left = 0;
	int              rsp_gap;
	console_result_t want;

	text_console_writer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.action        (action),
		.character     (character),
		.entry_color   (entry_color),
		.column        (column),
		.line          (line),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.cursor_offset (cursor_offset),
		.cell_data     (cell_data)
	);

	// Clock: 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one word to the shadow console and returns the result it causes.
	function automatic console_result_t predict_console(logic [ACT_W-1:0] act,
			logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] attr,
			logic [COL_W-1:0] col, logic [ROW_W-1:0] ln);
		console_result_t r;
		logic [CELL_W-1:0] blank_cell;
		blank_cell = {screen_attr, CH_BLANK};
		r.cell_word = '0;
		case (act)
			ACT_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen_cells[i] = blank_cell;
				cur_col = 0;
				cur_row = 0;
			end
			ACT_PUT_CHAR: begin
				if (ch == CH_NEWLINE) begin
					cur_row++;
					cur_col = 0;
				end else if (ch == CH_BACKSPACE) begin
					if (cur_col == 0) begin
						cur_col = COLUMNS - 1;
						if (cur_row != 0)
							cur_row--;
					end else begin
						cur_col--;
					end
					screen_cells[cur_row * COLUMNS + cur_col] = blank_cell;
				end else begin
					screen_cells[cur_row * COLUMNS + cur_col] = {screen_attr, ch};
					cur_col++;
					if (cur_col >= COLUMNS) begin
						cur_col = 0;
						cur_row++;
					end
				end
				// Running off the bottom scrolls everything up one row.
				if (cur_row >= ROWS) begin
					cur_row = ROWS - 1;
					for (int i = 0; i < CELLS - COLUMNS; i++)
						screen_cells[i] = screen_cells[i + COLUMNS];
					for (int i = CELLS - COLUMNS; i < CELLS; i++)
						screen_cells[i] = blank_cell;
				end
			end
			ACT_PUT_CELL: begin
				if (col < COLUMNS && ln < ROWS)
					screen_cells[ln * COLUMNS + col] = {attr, ch};
			end
			default: begin
				if (col < COLUMNS && ln < ROWS)
					r.cell_word = screen_cells[ln * COLUMNS + col];
			end
		endcase
		r.offset = OFFSET_W'(cur_row * COLUMNS + cur_col);
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Positions are mostly on screen, sometimes anywhere the fields allow.
	function automatic logic [COL_W-1:0] pick_column();
		if ($urandom_range(0, 99) < 85)
			return COL_W'($urandom_range(0, COLUMNS - 1));
		return COL_W'($urandom);
	endfunction

	function automatic logic [ROW_W-1:0] pick_line();
		if ($urandom_range(0, 99) < 85)
			return ROW_W'($urandom_range(0, ROWS - 1));
		return ROW_W'($urandom);
	endfunction

	function automatic void note_failure(string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("%s", msg);
	endfunction

	// Sends one word and records the result it should produce.
	task automatic send_word(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] ch,
			input logic [COLOR_W-1:0] attr, input logic [COL_W-1:0] col,
			input logic [ROW_W-1:0] ln);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid   <= 1'b1;
		action      <= act;
		character   <= ch;
		entry_color <= attr;
		column      <= col;
		line        <= ln;
		do @(posedge clk); while (!cmd_ready);
		pending_results.push_back(predict_console(act, ch, attr, col, ln));
	endtask

	// Drops valid and waits until every outstanding result has come back.
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic write_color(input logic [COLOR_W-1:0] value);
		wait_idle();
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		screen_attr = value;
		cfg_write_en <= 1'b0;
	endtask

	// A fresh store reads back as blanks in the reset color.
	task automatic test_reset_contents();
		send_word(ACT_READ, CHAR_W'($urandom), COLOR_W'($urandom), '0, '0);
		send_word(ACT_READ, CHAR_W'($urandom), COLOR_W'($urandom), COL_W'(COLUMNS - 1),
			ROW_W'(ROWS - 1));
	endtask

	// Explicit cell writes at the corners, and positions off the screen.
	task automatic test_cell_access();
		send_word(ACT_PUT_CELL, 8'hFF, 8'hFF, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
		send_word(ACT_READ, 8'h00, 8'h00, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
		send_word(ACT_PUT_CELL, 8'h00, 8'h00, '0, '0);
		send_word(ACT_READ, 8'hFF, 8'hFF, '0, '0);
		send_word(ACT_PUT_CELL, 8'h55, 8'hAA, COL_W'(COLUMNS), '0);
		send_word(ACT_PUT_CELL, 8'hAA, 8'h55, '0, ROW_W'(ROWS));
		send_word(ACT_PUT_CELL, 8'hFF, 8'hFF, '1, '1);
		send_word(ACT_READ, 8'h00, 8'h00, '1, '1);
		send_word(ACT_READ, 8'h00, 8'h00, COL_W'(COLUMNS), '0);
	endtask

	// Backspace at the left edge, wrap at the right edge, and newline.
	task automatic test_cursor_edges();
		send_word(ACT_PUT_CHAR, CH_BACKSPACE, COLOR_W'($urandom), COL_W'($urandom),
			ROW_W'($urandom));
		send_word(ACT_PUT_CHAR, 8'h41, COLOR_W'($urandom), COL_W'($urandom),
			ROW_W'($urandom));
		send_word(ACT_PUT_CHAR, CH_BACKSPACE, 8'h00, '0, '0);
		send_word(ACT_PUT_CHAR, CH_NEWLINE, 8'hFF, '1, '1);
		send_word(ACT_PUT_CHAR, 8'hFF, 8'h00, '0, '0);
		send_word(ACT_PUT_CHAR, 8'h00, 8'hFF, '1, '1);
		send_word(ACT_READ, 8'h00, 8'h00, '0, ROW_W'(1));
	endtask

	// Clear fills with blanks in the current color and homes the cursor.
	task automatic test_clear();
		write_color(8'hF0);
		send_word(ACT_CLEAR, CHAR_W'($urandom), COLOR_W'($urandom), COL_W'($urandom),
			ROW_W'($urandom));
		send_word(ACT_READ, 8'h00, 8'h00, COL_W'(40), ROW_W'(12));
	endtask

	// Random traffic, shaped mostly as text runs and cell write/read pairs.
	task automatic test_random_traffic(input int n_items);
		int sent;
		int kind;
		int run_len;
		int r;
		logic [CHAR_W-1:0] ch;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  ln;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				// A run of text with the odd newline and backspace.
				run_len = $urandom_range(1, 30);
				repeat (run_len) begin
					r = $urandom_range(0, 99);
					if (r < 8)
						ch = CH_NEWLINE;
					else if (r < 15)
						ch = CH_BACKSPACE;
					else
						ch = CHAR_W'($urandom);
					send_word(ACT_PUT_CHAR, ch, COLOR_W'($urandom), COL_W'($urandom),
						ROW_W'($urandom));
					sent++;
				end
			end else if (kind < 58) begin
				// A burst of newlines pushes the cursor down, scrolling once it reaches the bottom.
				run_len = $urandom_range(3, 20);
				repeat (run_len) begin
					send_word(ACT_PUT_CHAR, CH_NEWLINE, COLOR_W'($urandom),
						COL_W'($urandom), ROW_W'($urandom));
					sent++;
				end
			end else if (kind < 78) begin
				col = pick_column();
				ln  = pick_line();
				send_word(ACT_PUT_CELL, CHAR_W'($urandom), COLOR_W'($urandom), col, ln);
				send_word(ACT_READ, CHAR_W'($urandom), COLOR_W'($urandom), col, ln);
				sent += 2;
			end else if (kind < 90) begin
				send_word(ACT_READ, CHAR_W'($urandom), COLOR_W'($urandom), pick_column(),
					pick_line());
				sent++;
			end else if (kind < 93) begin
				send_word(ACT_CLEAR, CHAR_W'($urandom), COLOR_W'($urandom),
					COL_W'($urandom), ROW_W'($urandom));
				sent++;
			end else begin
				send_word(ACT_W'($urandom), CHAR_W'($urandom), COLOR_W'($urandom),
					COL_W'($urandom), ROW_W'($urandom));
				sent++;
			end
		end
	endtask

	// Result side: random back-pressure and comparison with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					note_failure($sformatf("%0t: result with no word outstanding: offset %0d cell %h",
						$realtime, cursor_offset, cell_data));
				end else begin
					want = pending_results.pop_front();
					if (cursor_offset !== want.offset || cell_data !== want.cell_word)
						note_failure($sformatf(
							"%0t: mismatch: offset exp %0d got %0d, cell exp %h got %h",
							$realtime, want.offset, cursor_offset, want.cell_word, cell_data));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
			end else if (rsp_ready) begin
				rsp_gap = pick_gap();
				if (rsp_gap > 0) begin
					rsp_ready <= 1'b0;
					hold_left = rsp_gap - 1;
				end else begin
					hold_left = $urandom_range(0, 6);
				end
			end else begin
				rsp_ready <= 1'b1;
				hold_left = $urandom_range(0, 6);
			end
		end
	end

	// Hard limit on the run.
	initial begin
		#(TIMEOUT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	// Test sequence.
	initial begin
		for (int i = 0; i < CELLS; i++)
			screen_cells[i] = RESET_CELL;
		cur_col     = 0;
		cur_row     = 0;
		screen_attr = RESET_COLOR;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_contents();
		test_cell_access();
		test_cursor_edges();
		test_clear();

		// Random phases under different attributes; one phase without idling.
		write_color(8'h00);
		quiet = 1'b0;
		test_random_traffic(200);
		write_color(8'hFF);
		quiet = 1'b1;
		test_random_traffic(150);
		write_color(COLOR_W'($urandom));
		quiet = 1'b0;
		test_random_traffic(250);
		write_color(RESET_COLOR);
		test_random_traffic(200);
		write_color(COLOR_W'($urandom));
		test_random_traffic(250);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
